// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`endif

// ===== hw/rtl/gfm_pkg.sv =====
package gfm_pkg;

	localparam int ElemBits = 128;
	localparam int HalfBits = ElemBits / 2;
	localparam int CellBits = 8;
	localparam int NumCells = ElemBits / CellBits;
	localparam logic [7:0] RPoly = 8'hE1;

	typedef logic [ElemBits-1:0] gf_elem_t;

	typedef struct packed {
		gf_elem_t a;
		gf_elem_t v;
		gf_elem_t z;
	} gfm_beat_t;

	// one cell's worth of shift-and-add steps, operand a consumed msb first
	function automatic gfm_beat_t gfm_steps(gfm_beat_t b_in);
		gfm_beat_t b;
		logic carry;
		b = b_in;
		for (int i = 0; i < CellBits; i++) begin
			if (b.a[ElemBits-1]) begin
				b.z = b.z ^ b.v;
			end
			carry = b.v[0];
			b.v = {1'b0, b.v[ElemBits-1:1]};
			if (carry) begin
				b.v[ElemBits-1 -: 8] = b.v[ElemBits-1 -: 8] ^ RPoly;
			end
			b.a = {b.a[ElemBits-2:0], 1'b0};
		end
		return b;
	endfunction

endpackage

// ===== hw/rtl/gfm_cell.sv =====
module gfm_cell
	import gfm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	input  gfm_beat_t up_beat,
	output logic      up_ready,
	output logic      down_valid,
	output gfm_beat_t down_beat,
	input  logic      down_ready
);

	logic      valid_q;
	gfm_beat_t beat_s1;
	gfm_beat_t next_beat;

	assign next_beat  = gfm_steps(up_beat);
	assign up_ready   = !valid_q || down_ready;
	assign down_valid = valid_q;
	assign down_beat  = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			beat_s1 <= next_beat;
		end
	end

endmodule

// ===== hw/rtl/gf128_multiply.sv =====
// gcm field multiplier, 16 cells of 8 operand bits each
// path: a product passes through the register of each cell in order, one per cell, before it shows on the outputs
// throughput: one multiply per cycle while rsp_stall is low, set by the cell pipeline, none skipped
// stall from the output ripples back only into cells that hold a beat
// reset: asynchronous, clears every cell's valid flag; data registers are not reset
module gf128_multiply
	import gfm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [HalfBits-1:0] a_hi,
	input  logic [HalfBits-1:0] a_lo,
	input  logic [HalfBits-1:0] b_hi,
	input  logic [HalfBits-1:0] b_lo,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [HalfBits-1:0] product_hi,
	output logic [HalfBits-1:0] product_lo
);

	gfm_beat_t chain_beat  [NumCells+1];
	logic      chain_valid [NumCells+1];
	logic      chain_ready [NumCells+1];

	assign chain_beat[0].a = {a_hi, a_lo};
	assign chain_beat[0].v = {b_hi, b_lo};
	assign chain_beat[0].z = '0;
	assign chain_valid[0]  = req_valid;
	assign req_stall       = !chain_ready[0];

	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		gfm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (chain_valid[k]),
			.up_beat    (chain_beat[k]),
			.up_ready   (chain_ready[k]),
			.down_valid (chain_valid[k+1]),
			.down_beat  (chain_beat[k+1]),
			.down_ready (chain_ready[k+1])
		);
	end

	assign chain_ready[NumCells] = !rsp_stall;
	assign rsp_valid  = chain_valid[NumCells];
	assign product_hi = chain_beat[NumCells].z[ElemBits-1:HalfBits];
	assign product_lo = chain_beat[NumCells].z[HalfBits-1:0];

endmodule

// ===== hw/rtl/gfm_checker.sv =====
`include "assert_macros.svh"

module gfm_checker
	import gfm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic [HalfBits-1:0] product_hi,
	input logic [HalfBits-1:0] product_lo
);

	// an empty output slot means the whole chain can move
	`ASSERT_IMPL(a_empty_no_stall, !rsp_valid, !req_stall)
	// a draining output means every cell can move
	`ASSERT_IMPL(a_drain_no_stall, !rsp_stall, !req_stall)
	`ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid)
	`ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall,
		$stable(product_hi) && $stable(product_lo))

endmodule

bind gf128_multiply gfm_checker u_gfm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.product_hi (product_hi),
	.product_lo (product_lo)
);
